// ===== rtl/lskt_pkg.sv =====
// Package for the linear search key table: sizes, opcodes, states and the
// structs passed between the controller and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lskt_pkg;

   localparam int TABLE_DEPTH   = 4096;
   localparam int PAYLOAD_BITS  = 32;
   localparam int HASH_W        = 64;
   localparam int KEY_W         = HASH_W + 1;
   localparam int IDX_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
   localparam int OPCODE_W      = 2;
   localparam int CAP_W         = 13;
   localparam int PAYLOAD_IN_W  = 32;
   localparam int ENTRY_INDEX_W = 12;
   localparam int PAYLOAD_OUT_W = 32;
   localparam int COUNT_OUT_W   = 13;

   localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [IDX_W-1:0]        rd_addr;
      logic [IDX_W-1:0]        wr_addr;
      logic                    key_we;
      logic                    pay_we;
      logic [KEY_W-1:0]        key_wdata;
      logic [PAYLOAD_BITS-1:0] pay_wdata;
   } ram_ctrl_type;

   typedef struct packed {
      logic                     accepted;
      logic                     found;
      logic [ENTRY_INDEX_W-1:0] entry_index;
      logic [PAYLOAD_OUT_W-1:0] payload_out;
      logic [COUNT_OUT_W-1:0]   entry_count;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/lskt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lskt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ===== rtl/lskt_ctrl.sv =====
// Search controller: operation sequencing, key scan over the key memory,
// entry count, capacity register and result register. Uses lskt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lskt_ctrl
   import lskt_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wr_en,
   input  wire logic [CAP_W-1:0]         csr_wr_data,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [OPCODE_W-1:0]      req_opcode,
   input  wire logic [HASH_W-1:0]        req_key_hash,
   input  wire logic                     req_side_to_move,
   input  wire logic [PAYLOAD_IN_W-1:0]  req_payload_in,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rsp_type                       rsp_data,
   output ram_ctrl_type                  ram_ctrl,
   input  wire logic [KEY_W-1:0]         key_rdata,
   input  wire logic [PAYLOAD_BITS-1:0]  pay_rdata
);

   state_type               state_ff, state_in;
   logic [OPCODE_W-1:0]     op_ff, op_in;
   logic [HASH_W-1:0]       hash_ff, hash_in;
   logic                    side_ff, side_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CAP_W-1:0]        cap_ff, cap_in;
   logic [CNT_W-1:0]        next_addr_ff, next_addr_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]        chk_idx_ff, chk_idx_in;
   rsp_type                 res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   logic                    issue;
   logic                    hit;
   logic                    cap_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      hash_ff      <= hash_in;
      side_ff      <= side_in;
      pay_ff       <= pay_in;
      next_addr_ff <= next_addr_in;
      chk_idx_ff   <= chk_idx_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      hash_in      = hash_ff;
      side_in      = side_ff;
      pay_in       = pay_ff;
      count_in     = count_ff;
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      next_addr_in = next_addr_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      ram_ctrl.rd_addr   = next_addr_ff[IDX_W-1:0];
      ram_ctrl.wr_addr   = chk_idx_ff;
      ram_ctrl.key_we    = 1'b0;
      ram_ctrl.pay_we    = 1'b0;
      ram_ctrl.key_wdata = {hash_ff, side_ff};
      ram_ctrl.pay_wdata = pay_ff;

      issue  = next_addr_ff < count_ff;
      hit    = chk_vld_ff && (key_rdata == {hash_ff, side_ff});
      cap_ok = (32'(count_ff) < 32'(cap_ff)) && (32'(count_ff) < 32'(TABLE_DEPTH));

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in              = req_opcode;
               hash_in            = req_key_hash;
               side_in            = req_side_to_move;
               pay_in             = PAYLOAD_BITS'(req_payload_in);
               next_addr_in       = '0;
               res_in             = '0;
               res_in.entry_count = COUNT_OUT_W'(count_ff);
               case (req_opcode)
                  OP_LOOKUP: begin
                     state_in = ST_SCAN;
                  end
                  OP_INSERT: begin
                     state_in = cap_ok ? ST_SCAN : ST_FINISH;
                  end
                  OP_CLEAR: begin
                     count_in           = '0;
                     res_in.accepted    = 1'b1;
                     res_in.entry_count = '0;
                     state_in           = ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               next_addr_in = next_addr_ff + 1'b1;
               chk_vld_in   = 1'b1;
               chk_idx_in   = next_addr_ff[IDX_W-1:0];
            end
            if (hit) begin
               res_in.accepted    = 1'b1;
               res_in.found       = 1'b1;
               res_in.entry_index = ENTRY_INDEX_W'(chk_idx_ff);
               if (op_ff == OP_LOOKUP) begin
                  res_in.payload_out = PAYLOAD_OUT_W'(pay_rdata);
               end else begin
                  ram_ctrl.pay_we = 1'b1;
               end
               state_in = ST_FINISH;
            end else if (!issue) begin
               res_in.accepted = 1'b1;
               if (op_ff == OP_INSERT) begin
                  ram_ctrl.wr_addr   = count_ff[IDX_W-1:0];
                  ram_ctrl.key_we    = 1'b1;
                  ram_ctrl.pay_we    = 1'b1;
                  res_in.entry_index = ENTRY_INDEX_W'(count_ff);
                  count_in           = CNT_W'(count_ff + 1'b1);
                  res_in.entry_count = COUNT_OUT_W'(count_ff + 1'b1);
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/linear_search_key_table_top.sv =====
// Top level of the linear search key table: controller plus key and payload
// memories. Uses lskt_pkg, lskt_ctrl and lskt_ram.
`timescale 1ns / 1ps
`default_nettype none

// The table holds up to 4096 entries, each a 64-bit hash plus a side bit with
// a 32-bit payload, kept in the first entry_count slots of two memories. A
// lookup or an accepted insert scans the stored keys from slot 0, one key per
// cycle through the registered read port of the key memory, and stops at the
// first match. A clear, a refused insert or an unused opcode skips the scan.
// The result waits in an output register, and the block takes the next item as
// soon as the current one has finished. The memories need no clearing pass: the
// entry count marks which slots hold data. Write capacity_limit only while the
// block is idle.

module linear_search_key_table_top
   import lskt_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wr_en,
   input  wire logic [CAP_W-1:0]         csr_wr_data,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [OPCODE_W-1:0]      req_opcode,
   input  wire logic [HASH_W-1:0]        req_key_hash,
   input  wire logic                     req_side_to_move,
   input  wire logic [PAYLOAD_IN_W-1:0]  req_payload_in,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_accepted,
   output logic                          rsp_found,
   output logic [ENTRY_INDEX_W-1:0]      rsp_entry_index,
   output logic [PAYLOAD_OUT_W-1:0]      rsp_payload_out,
   output logic [COUNT_OUT_W-1:0]        rsp_entry_count
);

   ram_ctrl_type            ram_ctrl;
   rsp_type                 rsp_data;
   logic [KEY_W-1:0]        key_rdata;
   logic [PAYLOAD_BITS-1:0] pay_rdata;

   lskt_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_key_hash     (req_key_hash),
      .req_side_to_move (req_side_to_move),
      .req_payload_in   (req_payload_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .ram_ctrl         (ram_ctrl),
      .key_rdata        (key_rdata),
      .pay_rdata        (pay_rdata)
   );

   lskt_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_key_ram (
      .clock (clock),
      .we    (ram_ctrl.key_we),
      .waddr (ram_ctrl.wr_addr),
      .wdata (ram_ctrl.key_wdata),
      .raddr (ram_ctrl.rd_addr),
      .rdata (key_rdata)
   );

   lskt_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_pay_ram (
      .clock (clock),
      .we    (ram_ctrl.pay_we),
      .waddr (ram_ctrl.wr_addr),
      .wdata (ram_ctrl.pay_wdata),
      .raddr (ram_ctrl.rd_addr),
      .rdata (pay_rdata)
   );

   assign rsp_accepted    = rsp_data.accepted;
   assign rsp_found       = rsp_data.found;
   assign rsp_entry_index = rsp_data.entry_index;
   assign rsp_payload_out = rsp_data.payload_out;
   assign rsp_entry_count = rsp_data.entry_count;

endmodule

`default_nettype wire

// ===== rtl/lskt_checker.sv =====
// Port-level checks for linear_search_key_table_top, bound to the top level.
// Uses lskt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lskt_checker
   import lskt_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     csr_wr_en,
   input wire logic [CAP_W-1:0]         csr_wr_data,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic [OPCODE_W-1:0]      req_opcode,
   input wire logic [HASH_W-1:0]        req_key_hash,
   input wire logic                     req_side_to_move,
   input wire logic [PAYLOAD_IN_W-1:0]  req_payload_in,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic                     rsp_accepted,
   input wire logic                     rsp_found,
   input wire logic [ENTRY_INDEX_W-1:0] rsp_entry_index,
   input wire logic [PAYLOAD_OUT_W-1:0] rsp_payload_out,
   input wire logic [COUNT_OUT_W-1:0]   rsp_entry_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_accepted) && $stable(rsp_found)
         && $stable(rsp_entry_index) && $stable(rsp_payload_out) && $stable(rsp_entry_count))
      else $error("result item changed while stalled");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> !rsp_found && rsp_entry_index == '0
         && rsp_payload_out == '0)
      else $error("refused insert carries nonzero fields");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_entry_count) <= 32'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_found_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> 32'(rsp_entry_index) < 32'(rsp_entry_count))
      else $error("matching index outside the valid entries");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind linear_search_key_table_top lskt_checker u_lskt_checker (.*);

`default_nettype wire

// ===== dv/tb_linear_search_key_table_top.sv =====
// Testbench for linear_search_key_table_top: drives lookup, insert, clear and
// unused-opcode items, predicts each result from a table mirror and compares it
// field by field. Depends on lskt_pkg and the RTL of linear_search_key_table_top.
`timescale 1ns / 1ps

module tb_linear_search_key_table_top;
   import lskt_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [CAP_W-1:0] CAP_FIELD_MAX = 13'd8191;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_AFTER = 140;
   localparam int HOLD_CYCLES = 120;
   localparam int POOL_SIZE = 8;

   typedef struct packed {
      logic [OPCODE_W-1:0]     opcode;
      logic [HASH_W-1:0]       key_hash;
      logic                    side;
      logic [PAYLOAD_IN_W-1:0] payload;
   } table_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CAP_W-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [OPCODE_W-1:0] req_opcode = '0;
   logic [HASH_W-1:0] req_key_hash = '0;
   logic req_side_to_move = 1'b0;
   logic [PAYLOAD_IN_W-1:0] req_payload_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_accepted;
   logic rsp_found;
   logic [ENTRY_INDEX_W-1:0] rsp_entry_index;
   logic [PAYLOAD_OUT_W-1:0] rsp_payload_out;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;

   logic [KEY_W-1:0] key_mirror [TABLE_DEPTH];
   logic [PAYLOAD_BITS-1:0] payload_mirror [TABLE_DEPTH];
   int unsigned count_mirror = 0;
   int unsigned capacity_mirror = 4096;

   table_req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   table_req_type next_req;
   rsp_type expected_rsp;
   logic [HASH_W-1:0] key_pool [POOL_SIZE];

   int sender_idle_pct = 22;
   int receiver_idle_pct = 59;
   int items_sent = 0;
   int results_checked = 0;
   int error_count = 0;
   int quiet_cycles = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   linear_search_key_table_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_key_hash     (req_key_hash),
      .req_side_to_move (req_side_to_move),
      .req_payload_in   (req_payload_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_found        (rsp_found),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_payload_out  (rsp_payload_out),
      .rsp_entry_count  (rsp_entry_count)
   );

   always #1 clock = ~clock;

   function automatic rsp_type table_step(logic [OPCODE_W-1:0] opcode,
                                          logic [HASH_W-1:0] key_hash, logic side,
                                          logic [PAYLOAD_IN_W-1:0] payload);
      rsp_type res;
      logic [KEY_W-1:0] key;
      int unsigned limit;
      int hit;
      res = '0;
      key = {side, key_hash};
      limit = (capacity_mirror > TABLE_DEPTH) ? TABLE_DEPTH : capacity_mirror;
      hit = -1;
      if (opcode == OP_LOOKUP || (opcode == OP_INSERT && count_mirror < limit)) begin
         for (int i = 0; i < count_mirror; i++) begin
            if (hit < 0 && key_mirror[i] == key) begin
               hit = i;
            end
         end
      end
      case (opcode)
         OP_LOOKUP: begin
            res.accepted = 1'b1;
            if (hit >= 0) begin
               res.found = 1'b1;
               res.entry_index = hit[ENTRY_INDEX_W-1:0];
               res.payload_out = payload_mirror[hit];
            end
         end
         OP_INSERT: begin
            if (count_mirror < limit) begin
               res.accepted = 1'b1;
               if (hit >= 0) begin
                  res.found = 1'b1;
                  res.entry_index = hit[ENTRY_INDEX_W-1:0];
                  payload_mirror[hit] = payload[PAYLOAD_BITS-1:0];
               end else begin
                  key_mirror[count_mirror] = key;
                  payload_mirror[count_mirror] = payload[PAYLOAD_BITS-1:0];
                  res.entry_index = count_mirror[ENTRY_INDEX_W-1:0];
                  count_mirror++;
               end
            end
         end
         OP_CLEAR: begin
            res.accepted = 1'b1;
            count_mirror = 0;
         end
         default: begin
         end
      endcase
      res.entry_count = count_mirror[COUNT_OUT_W-1:0];
      return res;
   endfunction

   function automatic table_req_type random_req();
      table_req_type r;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 4) begin
         r.opcode = OP_CLEAR;
      end else if (pick < 9) begin
         r.opcode = OP_UNUSED;
      end else if (pick < 50) begin
         r.opcode = OP_LOOKUP;
      end else begin
         r.opcode = OP_INSERT;
      end
      if ($urandom_range(4) != 0) begin
         r.key_hash = key_pool[$urandom_range(POOL_SIZE - 1)];
      end else begin
         r.key_hash = {$urandom, $urandom};
      end
      r.side = 1'($urandom_range(1));
      r.payload = $urandom;
      return r;
   endfunction

   task automatic queue_req(logic [OPCODE_W-1:0] opcode, logic [HASH_W-1:0] key_hash,
                            logic side, logic [PAYLOAD_IN_W-1:0] payload);
      pending_reqs.push_back('{opcode, key_hash, side, payload});
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      capacity_mirror = 32'(value);
      @(negedge clock);
   endtask

   task automatic check_field(string name, logic [63:0] expected, logic [63:0] actual);
      if (expected !== actual) begin
         $error("%s: expected %0h, got %0h", name, expected, actual);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(table_step(req_opcode, req_key_hash, req_side_to_move,
                                               req_payload_in));
            items_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_req = pending_reqs.pop_front();
               req_opcode <= next_req.opcode;
               req_key_hash <= next_req.key_hash;
               req_side_to_move <= next_req.side;
               req_payload_in <= next_req.payload;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_checked >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (expected_rsps.size() == 0) begin
            $error("result arrived with no item outstanding");
            error_count++;
         end else begin
            expected_rsp = expected_rsps.pop_front();
            check_field("accepted", expected_rsp.accepted, rsp_accepted);
            check_field("found", expected_rsp.found, rsp_found);
            check_field("entry_index", expected_rsp.entry_index, rsp_entry_index);
            check_field("payload_out", expected_rsp.payload_out, rsp_payload_out);
            check_field("entry_count", expected_rsp.entry_count, rsp_entry_count);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("Timed out with %0d results still outstanding.", expected_rsps.size());
         $display("[linear_search_key_table_top] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [HASH_W-1:0] key_a;
      logic [HASH_W-1:0] key_b;
      logic [HASH_W-1:0] key_c;
      key_a = {$urandom, $urandom};
      key_b = {$urandom, $urandom};
      key_c = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) begin
         key_pool[i] = {$urandom, $urandom};
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_capacity(CAP_FIELD_MAX);
      queue_req(OP_LOOKUP, '0, 1'b0, $urandom);
      queue_req(OP_INSERT, '0, 1'b0, 32'h0000_0000);
      queue_req(OP_INSERT, '1, 1'b1, 32'hffff_ffff);
      queue_req(OP_INSERT, '1, 1'b0, 32'h5555_5555);
      queue_req(OP_LOOKUP, '1, 1'b1, $urandom);
      queue_req(OP_LOOKUP, '1, 1'b0, $urandom);
      queue_req(OP_INSERT, '0, 1'b0, 32'ha5a5_a5a5);
      queue_req(OP_LOOKUP, '0, 1'b0, $urandom);
      queue_req(OP_UNUSED, {$urandom, $urandom}, 1'b1, $urandom);
      queue_req(OP_LOOKUP, '0, 1'b1, $urandom);
      queue_req(OP_CLEAR, {$urandom, $urandom}, 1'b0, $urandom);
      queue_req(OP_LOOKUP, '0, 1'b0, $urandom);
      queue_req(OP_INSERT, key_a, 1'b1, 32'h1234_5678);
      wait_drained();

      write_capacity(13'd2);
      queue_req(OP_INSERT, key_b, 1'b0, $urandom);
      queue_req(OP_INSERT, key_c, 1'b0, $urandom);
      queue_req(OP_INSERT, key_a, 1'b1, $urandom);
      queue_req(OP_LOOKUP, key_a, 1'b1, $urandom);
      wait_drained();

      write_capacity(13'd0);
      queue_req(OP_INSERT, key_c, 1'b1, $urandom);
      queue_req(OP_LOOKUP, key_b, 1'b0, $urandom);
      queue_req(OP_CLEAR, '0, 1'b0, $urandom);
      queue_req(OP_INSERT, key_c, 1'b1, $urandom);
      wait_drained();

      write_capacity(13'd1);
      queue_req(OP_INSERT, key_c, 1'b0, $urandom);
      queue_req(OP_INSERT, key_c, 1'b0, $urandom);
      queue_req(OP_LOOKUP, key_c, 1'b0, $urandom);
      wait_drained();

      write_capacity(13'd4096);
      for (int i = 0; i < 50; i++) begin
         pending_reqs.push_back(random_req());
      end
      wait_drained();

      sender_idle_pct = 59;
      receiver_idle_pct = 22;
      write_capacity(CAP_W'($urandom_range(12, 4)));
      for (int i = 0; i < 50; i++) begin
         pending_reqs.push_back(random_req());
      end
      wait_drained();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      write_capacity(CAP_FIELD_MAX);
      for (int i = 0; i < 40; i++) begin
         pending_reqs.push_back(random_req());
      end
      wait_drained();
      repeat (10) @(posedge clock);

      $display("Sent %0d items and checked %0d results over capacity limits 0, 1, 2,",
               items_sent, results_checked);
      $display("a small random limit, 4096 and 8191, with random stalls and one long hold-off.");
      if (error_count == 0) begin
         $display("[linear_search_key_table_top] OK");
      end else begin
         $display("[linear_search_key_table_top] ERROR");
      end
      $finish;
   end

endmodule

// ===== linear_search_key_table_top.f =====
rtl/lskt_pkg.sv
rtl/lskt_ram.sv
rtl/lskt_ctrl.sv
rtl/linear_search_key_table_top.sv
rtl/lskt_checker.sv
dv/tb_linear_search_key_table_top.sv
